FILE: rtl/rdmc_pkg.sv
// shared types, constants and helpers of the maze carver
`timescale 1ns / 1ps

package rdmc_pkg;

  // grid geometry (side is a power of two, cell index is {row, column})
  localparam int GRID_SIDE = 128;
  localparam int COORD_W   = $clog2(GRID_SIDE);
  localparam int CELL_W    = 2 * COORD_W;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int SP_W      = CELL_W + 1;
  localparam int DIST_W    = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;

  // command codes
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // event codes
  localparam logic [2:0] EV_STARTED = 3'd0;
  localparam logic [2:0] EV_CARVED  = 3'd1;
  localparam logic [2:0] EV_BACK    = 3'd2;
  localparam logic [2:0] EV_END     = 3'd3;
  localparam logic [2:0] EV_DONE    = 3'd4;

  // direction codes
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef enum logic [1:0] {
    KIND_WALL  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_START = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic       opcode;
    logic [4:0] order;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [DIST_W-1:0] distance;
    logic [SP_W-1:0]   stack_depth;
  } res_item_t;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } nbr_t;

  // trial orders in lexicographic order, first direction in the top bits
  localparam logic [7:0] PERM [24] = '{
    8'b00_01_10_11, 8'b00_01_11_10, 8'b00_10_01_11, 8'b00_10_11_01,
    8'b00_11_01_10, 8'b00_11_10_01, 8'b01_00_10_11, 8'b01_00_11_10,
    8'b01_10_00_11, 8'b01_10_11_00, 8'b01_11_00_10, 8'b01_11_10_00,
    8'b10_00_01_11, 8'b10_00_11_01, 8'b10_01_00_11, 8'b10_01_11_00,
    8'b10_11_00_01, 8'b10_11_01_00, 8'b11_00_01_10, 8'b11_00_10_01,
    8'b11_01_00_10, 8'b11_01_10_00, 8'b11_10_00_01, 8'b11_10_01_00
  };

  // neighbour of a cell in one direction, with an in-grid flag
  function automatic nbr_t nbr(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [1:0] d);
    nbr_t r;
    r.ok = 1'b1;
    r.x  = x;
    r.y  = y;
    case (d)
      DIR_UP: begin
        r.ok = (y != '0);
        r.y  = y - 1'b1;
      end
      DIR_LEFT: begin
        r.ok = (x != '0);
        r.x  = x - 1'b1;
      end
      DIR_DOWN: begin
        r.ok = (y != COORD_W'(GRID_SIDE - 1));
        r.y  = y + 1'b1;
      end
      default: begin
        r.ok = (x != COORD_W'(GRID_SIDE - 1));
        r.x  = x + 1'b1;
      end
    endcase
    return r;
  endfunction

  // start coordinate limited to the grid
  function automatic logic [COORD_W-1:0] clamp(input logic [CFG_W-1:0] v);
    return (32'(v) >= GRID_SIDE) ? COORD_W'(GRID_SIDE - 1) : COORD_W'(v);
  endfunction

endpackage

FILE: rtl/randomized_dfs_maze_carver.sv
// randomized depth-first maze carver: sequencer, grid memory and path stack memory
`timescale 1ns / 1ps

// One command item in, one result item out. A begin command sweeps the grid memory to walls,
// one entry a cycle, and then opens the start cell. A step command on a running maze reads
// the stack top and its distance, then tries the directions in the given order through the
// single read port of the grid memory: a direction that leaves the grid is skipped without a
// read, an open neighbour is rejected after one read, and a wall neighbour is read, then its
// four neighbours are read back to back. A step while idle, done or marking the end goes
// straight to its result. A new command is taken as soon as the previous result sits in the
// output register, even while that result still waits to be taken.
module randomized_dfs_maze_carver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  rdmc_pkg::cmd_item_t                 cmd,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rdmc_pkg::res_item_t                 res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rdmc_pkg::CFG_W-1:0]          cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CLEAR = 8'b0000_0010,
    ST_TOP   = 8'b0000_0100,
    ST_TOPD  = 8'b0000_1000,
    ST_DIR   = 8'b0001_0000,
    ST_NBK   = 8'b0010_0000,
    ST_CNT   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    rdmc_pkg::kind_t                  kind;
    logic [rdmc_pkg::DIST_W-1:0]      dist_val;
  } grid_word_t;

  localparam int CW = rdmc_pkg::CELL_W;
  localparam int XW = rdmc_pkg::COORD_W;

  state_t                      state;
  rdmc_pkg::phase_t            phase;
  logic [rdmc_pkg::CFG_W-1:0]  start_x;
  logic [rdmc_pkg::CFG_W-1:0]  start_y;
  logic [rdmc_pkg::SP_W-1:0]   sp;
  logic [rdmc_pkg::DIST_W-1:0] best_dist;
  logic [CW-1:0]               best_cell;
  logic [CW-1:0]               start_cell;
  logic [rdmc_pkg::SP_W-1:0]   clr;
  logic [7:0]                  perm;
  logic [2:0]                  tries;
  logic [CW-1:0]               top;
  logic [rdmc_pkg::DIST_W-1:0] top_dist;
  logic [XW-1:0]               nb_x;
  logic [XW-1:0]               nb_y;
  logic [2:0]                  rd_cnt;
  logic [2:0]                  open_cnt;
  logic                        inb_d;
  rdmc_pkg::res_item_t         pend;

  // memories and their ports
  grid_word_t                  grid_mem [rdmc_pkg::CELLS];
  logic [CW-1:0]               stk_mem  [rdmc_pkg::CELLS];
  logic                        g_re, g_we, s_re, s_we;
  logic [CW-1:0]               g_ra, g_wa, s_ra, s_wa, s_wd;
  grid_word_t                  g_wd, g_q;
  logic [CW-1:0]               s_q;

  // step decode
  logic                        cmd_acc;
  logic [4:0]                  ord_red;
  logic [rdmc_pkg::SP_W-1:0]   sp_m1;
  logic                        clr_done;
  rdmc_pkg::nbr_t              dn, cn;
  logic                        add_open;
  logic [2:0]                  open_tot;
  logic                        carve;
  logic [rdmc_pkg::DIST_W-1:0] nd;
  logic                        stk_room;
  logic [rdmc_pkg::SP_W-1:0]   sp_push;
  logic                        better;

  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign ord_red   = (cmd.order >= 5'd24) ? cmd.order - 5'd24 : cmd.order;
  assign sp_m1     = sp - 1'b1;
  assign clr_done  = (clr == rdmc_pkg::SP_W'(rdmc_pkg::CELLS));
  assign dn        = rdmc_pkg::nbr(top[XW-1:0], top[CW-1:XW], perm[7:6]);
  assign cn        = rdmc_pkg::nbr(nb_x, nb_y, rd_cnt[1:0]);
  assign add_open  = (rd_cnt != 3'd0) && inb_d && (g_q.kind != rdmc_pkg::KIND_WALL);
  assign open_tot  = open_cnt + {2'b0, add_open};
  assign carve     = (rd_cnt == 3'd4) && (open_tot == 3'd1);
  assign nd        = top_dist + 1'b1;
  assign stk_room  = (sp < rdmc_pkg::SP_W'(rdmc_pkg::CELLS));
  assign sp_push   = stk_room ? sp + 1'b1 : sp;
  assign better    = (nd > best_dist) || ((nd == best_dist) && ({nb_y, nb_x} < best_cell));

  // memory port control
  always_comb begin
    g_re = 1'b0;
    g_ra = '0;
    g_we = 1'b0;
    g_wa = '0;
    g_wd = '{kind: rdmc_pkg::KIND_WALL, dist_val: '0};
    s_re = 1'b0;
    s_ra = '0;
    s_we = 1'b0;
    s_wa = '0;
    s_wd = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_acc && (cmd.opcode == rdmc_pkg::OP_STEP) && (phase == rdmc_pkg::PH_RUN)) begin
          if (sp == '0) begin
            g_we = 1'b1;
            g_wa = best_cell;
            g_wd = '{kind: rdmc_pkg::KIND_END, dist_val: best_dist};
          end else begin
            s_re = 1'b1;
            s_ra = sp_m1[CW-1:0];
          end
        end
      end
      ST_CLEAR: begin
        g_we = 1'b1;
        if (clr_done) begin
          g_wa = start_cell;
          g_wd = '{kind: rdmc_pkg::KIND_START, dist_val: '0};
          s_we = 1'b1;
          s_wa = '0;
          s_wd = start_cell;
        end else begin
          g_wa = clr[CW-1:0];
        end
      end
      ST_TOP: begin
        g_re = 1'b1;
        g_ra = s_q;
      end
      ST_DIR: begin
        if ((tries != 3'd4) && dn.ok) begin
          g_re = 1'b1;
          g_ra = {dn.y, dn.x};
        end
      end
      ST_CNT: begin
        if (rd_cnt != 3'd4) begin
          g_re = 1'b1;
          g_ra = {cn.y, cn.x};
        end else if (carve) begin
          g_we = 1'b1;
          g_wa = {nb_y, nb_x};
          g_wd = '{kind: rdmc_pkg::KIND_OPEN, dist_val: nd};
          s_we = stk_room;
          s_wa = sp[CW-1:0];
          s_wd = {nb_y, nb_x};
        end
      end
      default: begin
      end
    endcase
  end

  // grid memory
  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    if (g_re) g_q <= grid_mem[g_ra];
  end

  // path stack memory
  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_wa] <= s_wd;
    if (s_re) s_q <= stk_mem[s_ra];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x <= '0;
      start_y <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdmc_pkg::REG_START_X: start_x <= cfg_data;
        rdmc_pkg::REG_START_Y: start_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= rdmc_pkg::PH_IDLE;
      sp        <= '0;
      best_dist <= '0;
      best_cell <= '0;
      res_valid <= 1'b0;
    end else begin
      // output register drains unless a new result is loaded below
      if (res_valid && res_ready && (state != ST_EMIT)) res_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_acc) begin
            if (cmd.opcode == rdmc_pkg::OP_BEGIN) begin
              start_cell <= {rdmc_pkg::clamp(start_y), rdmc_pkg::clamp(start_x)};
              clr        <= '0;
              state      <= ST_CLEAR;
            end else if (phase == rdmc_pkg::PH_IDLE) begin
              pend  <= '{event_res: rdmc_pkg::EV_DONE, default: '0};
              state <= ST_EMIT;
            end else if (phase == rdmc_pkg::PH_DONE) begin
              pend  <= '{rdmc_pkg::EV_DONE, best_cell[XW-1:0], best_cell[CW-1:XW],
                         best_dist, '0};
              state <= ST_EMIT;
            end else if (sp == '0) begin
              phase <= rdmc_pkg::PH_DONE;
              pend  <= '{rdmc_pkg::EV_END, best_cell[XW-1:0], best_cell[CW-1:XW],
                         best_dist, '0};
              state <= ST_EMIT;
            end else begin
              perm  <= rdmc_pkg::PERM[ord_red];
              tries <= '0;
              state <= ST_TOP;
            end
          end
        end
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr_done) begin
            sp        <= rdmc_pkg::SP_W'(1);
            best_dist <= '0;
            best_cell <= '0;
            phase     <= rdmc_pkg::PH_RUN;
            pend      <= '{rdmc_pkg::EV_STARTED, start_cell[XW-1:0], start_cell[CW-1:XW],
                           '0, rdmc_pkg::SP_W'(1)};
            state     <= ST_EMIT;
          end
        end
        ST_TOP: begin
          top   <= s_q;
          state <= ST_TOPD;
        end
        ST_TOPD: begin
          top_dist <= g_q.dist_val;
          state    <= ST_DIR;
        end
        ST_DIR: begin
          if (tries == 3'd4) begin
            // no carvable neighbour: pop the top
            sp    <= sp_m1;
            pend  <= '{rdmc_pkg::EV_BACK, top[XW-1:0], top[CW-1:XW], top_dist, sp_m1};
            state <= ST_EMIT;
          end else if (dn.ok) begin
            nb_x  <= dn.x;
            nb_y  <= dn.y;
            state <= ST_NBK;
          end else begin
            perm  <= {perm[5:0], perm[7:6]};
            tries <= tries + 1'b1;
          end
        end
        ST_NBK: begin
          if (g_q.kind != rdmc_pkg::KIND_WALL) begin
            perm  <= {perm[5:0], perm[7:6]};
            tries <= tries + 1'b1;
            state <= ST_DIR;
          end else begin
            rd_cnt   <= '0;
            open_cnt <= '0;
            state    <= ST_CNT;
          end
        end
        ST_CNT: begin
          // neighbour reads issue one a cycle, counts follow from the registered read data
          inb_d    <= cn.ok;
          open_cnt <= open_tot;
          rd_cnt   <= rd_cnt + 1'b1;
          if (rd_cnt == 3'd4) begin
            if (carve) begin
              sp <= sp_push;
              if (better) begin
                best_dist <= nd;
                best_cell <= {nb_y, nb_x};
              end
              pend  <= '{rdmc_pkg::EV_CARVED, nb_x, nb_y, nd, sp_push};
              state <= ST_EMIT;
            end else begin
              perm  <= {perm[5:0], perm[7:6]};
              tries <= tries + 1'b1;
              state <= ST_DIR;
            end
          end
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= rdmc_pkg::SP_W'(rdmc_pkg::CELLS))
    else $error("stack pointer beyond capacity");

  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == rdmc_pkg::PH_DONE) |-> (sp == '0))
    else $error("finished maze with a non-empty stack");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(g_we && g_re))
    else $error("grid read and write in the same cycle");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && (cmd.opcode == rdmc_pkg::OP_BEGIN)) |=> (state == ST_CLEAR))
    else $error("begin item did not start the clearing sweep");

  a_carve_dist: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.event_res == rdmc_pkg::EV_CARVED)) |-> (res.distance != '0))
    else $error("carved cell with zero distance");

endmodule
